// ===== design/positional_list_store_core_defines.svh =====
// Assertion macros used by the checker of the positional list store.
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/plsc_pkg.sv =====
// Package: sizes, codes, state and memory request types of the list store.
`timescale 1ns / 1ps
package plsc_pkg;
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [CMP_W-1:0]   cmp_t;
	typedef logic [VALUE_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT      = 3'd0,
		OP_DELETE      = 3'd1,
		OP_APPEND      = 3'd2,
		OP_REMOVE_TAIL = 3'd3,
		OP_READOUT     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_FIN,
		S_READ
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;
endpackage

// ===== design/plsc_in_if.sv =====
// Command channel interface: operation, value and position.
`timescale 1ns / 1ps
interface plsc_in_if import plsc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, op, value, position, input ready);
	modport sink (input valid, op, value, position, output ready);
endinterface

// ===== design/plsc_out_if.sv =====
// Response channel interface: status, count and stored entry.
`timescale 1ns / 1ps
interface plsc_out_if import plsc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        item_count;
	logic signed [VALUE_W-1:0] entry_value;
	logic                      entry_valid;
	logic                      last;

	modport source (output valid, status, item_count, entry_value, entry_valid, last,
		input ready);
	modport sink (input valid, status, item_count, entry_value, entry_valid, last,
		output ready);
endinterface

// ===== design/plsc_ram.sv =====
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module plsc_ram import plsc_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output word_t    rdata
);
	word_t mem_q [CAPACITY];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/plsc_ctrl.sv =====
// Sequencer: decodes commands, shifts entries through the memory, drives responses.
`timescale 1ns / 1ps
module plsc_ctrl import plsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	plsc_in_if.sink           cmd,
	plsc_out_if.source        rsp,
	output ram_req_t          ram_req,
	input  word_t             ram_rdata
);
	state_t  state_q, state_nxt;
	logic [OP_W-1:0] op_q;
	word_t   val_q;
	status_t status_q;
	addr_t   idx_q;
	cnt_t    cnt_q;
	addr_t   rd_ptr_q;
	cnt_t    rd_left_q;
	logic    pend_s1;
	addr_t   addr_s1;

	logic    rsp_valid_q;
	status_t rsp_status_q;
	cnt_t    rsp_count_q;
	word_t   rsp_value_q;
	logic    rsp_evalid_q;
	logic    rsp_last_q;

	status_t dec_status;
	logic    dec_shift, dec_fin, dec_read;
	addr_t   dec_rd_ptr, dec_idx;
	cnt_t    dec_rd_left;
	cmp_t    pos_c, cnt_c;
	logic    full, empty;

	logic    accept, slot_free, is_ins, ok_q;
	logic    sh_read, rd_load, rd_issue, fin_fire, rd_last;
	cnt_t    cnt_nxt;

	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign is_ins    = (op_q == OP_INSERT);
	assign ok_q      = (status_q == ST_OK);
	assign sh_read   = (state_q == S_SHIFT) && (rd_left_q != '0);
	assign rd_load   = (state_q == S_READ) && pend_s1 && slot_free;
	assign rd_issue  = (state_q == S_READ) && (rd_left_q != '0) && (!pend_s1 || rd_load);
	assign fin_fire  = (state_q == S_FIN) && slot_free;
	assign rd_last   = ((cnt_t'(addr_s1) + cnt_t'(1)) == cnt_q);

	assign pos_c = cmp_t'(cmd.position);
	assign cnt_c = cmp_t'(cnt_q);
	assign full  = (cnt_q == cnt_t'(CAPACITY));
	assign empty = (cnt_q == '0);

	// command decode
	always_comb begin
		dec_status  = ST_OK;
		dec_shift   = 1'b0;
		dec_fin     = 1'b0;
		dec_read    = 1'b0;
		dec_rd_ptr  = '0;
		dec_rd_left = '0;
		dec_idx     = '0;
		case (cmd.op)
			OP_INSERT: begin
				dec_fin = 1'b1;
				if (pos_c == '0 || pos_c > cnt_c + cmp_t'(1)) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_fin     = 1'b0;
					dec_shift   = 1'b1;
					dec_rd_ptr  = addr_t'(cnt_q - cnt_t'(1));
					dec_rd_left = cnt_t'(cnt_c - pos_c + cmp_t'(1));
					dec_idx     = addr_t'(pos_c - cmp_t'(1));
				end
			end
			OP_DELETE: begin
				dec_fin = 1'b1;
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (pos_c == '0 || pos_c > cnt_c) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_fin     = 1'b0;
					dec_shift   = 1'b1;
					dec_rd_ptr  = addr_t'(pos_c);
					dec_rd_left = cnt_t'(cnt_c - pos_c);
				end
			end
			OP_APPEND: begin
				dec_fin = 1'b1;
				dec_idx = addr_t'(cnt_q);
				if (full) begin
					dec_status = ST_FULL;
				end
			end
			OP_REMOVE_TAIL: begin
				dec_fin = 1'b1;
				if (empty) begin
					dec_status = ST_EMPTY;
				end
			end
			OP_READOUT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
					dec_fin    = 1'b1;
				end else begin
					dec_read    = 1'b1;
					dec_rd_left = cnt_q;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (dec_shift) begin
						state_nxt = S_SHIFT;
					end else if (dec_fin) begin
						state_nxt = S_FIN;
					end else if (dec_read) begin
						state_nxt = S_READ;
					end
				end
			end
			S_SHIFT: begin
				if (rd_left_q == '0) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_fire) begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: begin
				if (rd_left_q == '0 && (!pend_s1 || rd_load)) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs: handshake, memory request, count update
	always_comb begin
		cmd.ready     = (state_q == S_IDLE);
		ram_req.re    = sh_read || rd_issue;
		ram_req.raddr = rd_ptr_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = idx_q;
		ram_req.wdata = val_q;
		cnt_nxt       = cnt_q;
		case (state_q)
			S_SHIFT: begin
				ram_req.we    = pend_s1;
				ram_req.waddr = is_ins ? addr_s1 + addr_t'(1) : addr_s1 - addr_t'(1);
				ram_req.wdata = ram_rdata;
			end
			S_FIN: begin
				ram_req.we = fin_fire && ok_q && (is_ins || op_q == OP_APPEND);
				if (ok_q) begin
					if (is_ins || op_q == OP_APPEND) begin
						cnt_nxt = cnt_q + cnt_t'(1);
					end else if (op_q == OP_DELETE || op_q == OP_REMOVE_TAIL) begin
						cnt_nxt = cnt_q - cnt_t'(1);
					end
				end
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ram_req.re) begin
				pend_s1 <= 1'b1;
			end else if (state_q == S_SHIFT || rd_load) begin
				pend_s1 <= 1'b0;
			end
			if (fin_fire) begin
				cnt_q <= cnt_nxt;
			end
			if (fin_fire || rd_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cmd.op;
			val_q     <= cmd.value;
			status_q  <= dec_status;
			idx_q     <= dec_idx;
			rd_ptr_q  <= dec_rd_ptr;
			rd_left_q <= dec_rd_left;
		end else if (ram_req.re) begin
			rd_ptr_q  <= is_ins ? rd_ptr_q - addr_t'(1) : rd_ptr_q + addr_t'(1);
			rd_left_q <= rd_left_q - cnt_t'(1);
		end
		if (ram_req.re) begin
			addr_s1 <= rd_ptr_q;
		end
		if (fin_fire) begin
			rsp_status_q <= status_q;
			rsp_count_q  <= cnt_nxt;
			rsp_value_q  <= '0;
			rsp_evalid_q <= 1'b0;
			rsp_last_q   <= 1'b1;
		end else if (rd_load) begin
			rsp_status_q <= ST_OK;
			rsp_count_q  <= cnt_q;
			rsp_value_q  <= ram_rdata;
			rsp_evalid_q <= 1'b1;
			rsp_last_q   <= rd_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.item_count  = COUNT_W'(rsp_count_q);
	assign rsp.entry_value = rsp_value_q;
	assign rsp.entry_valid = rsp_evalid_q;
	assign rsp.last        = rsp_last_q;
endmodule

// ===== design/positional_list_store_core.sv =====
// Top level of the positional list store: sequencer plus entry memory.
// Append, remove tail and rejected edits pass from accept to S_FIN, which registers the
// response word once the output slot is free. Insert and delete first shift entries in
// S_SHIFT, one entry moved per cycle through the read and write ports of the memory.
// Readout: one word per cycle while the receiver takes each word; one item at a time.
// Reset (arst_n low, asynchronous): count and control clear; entries need no clearing.
`timescale 1ns / 1ps
module positional_list_store_core import plsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	plsc_in_if.sink    cmd,
	plsc_out_if.source rsp
);
	ram_req_t ram_req;
	word_t    ram_rdata;

	plsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	plsc_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);
endmodule

// ===== design/plsc_checker.sv =====
// Port checker for the list store, bound to the top level.
`timescale 1ns / 1ps
`include "positional_list_store_core_defines.svh"
module plsc_checker import plsc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [COUNT_W-1:0]  item_count,
	input logic [VALUE_W-1:0]  entry_value,
	input logic                entry_valid,
	input logic                last
);
	`PLSC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(entry_value) && $stable(status) && $stable(last), "stalled word changed")
	`PLSC_ASSERT_NOW(a_entry_ok, rsp_valid && entry_valid, status == ST_OK, "entry word with bad status")
	`PLSC_ASSERT_NOW(a_edit_word, rsp_valid && !entry_valid, last && entry_value == '0, "edit word not last or nonzero")
	`PLSC_ASSERT_NOW(a_empty_cnt, rsp_valid && status == ST_EMPTY, item_count == '0, "empty status with nonzero count")
endmodule

bind positional_list_store_core plsc_checker u_plsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.item_count  (rsp.item_count),
	.entry_value (rsp.entry_value),
	.entry_valid (rsp.entry_valid),
	.last        (rsp.last)
);

// ===== tb/tb_positional_list_store_core.sv =====
// Self-checking testbench for the positional list store, checked word by word.
`timescale 1ns / 1ps
module tb_positional_list_store_core;
	import plsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = CAPACITY + 8;
	localparam int MAX_PRINTS     = 50;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   item_count;
		word_t                entry_value;
		logic                 entry_valid;
		logic                 last;
	} list_word_t;

	logic clk;
	logic arst_n;

	plsc_in_if  cmd_if();
	plsc_out_if rsp_if();

	positional_list_store_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	word_t      list_model[$];
	list_word_t pending_words[$];
	list_word_t got_word;
	list_word_t want_word;
	int         mismatch_cnt;
	int         snd_idle_pct;
	int         rcv_idle_pct;
	int         rsp_hold_left;
	int         idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one expected word for an accepted command
	function automatic void push_expect(input status_t st, input word_t val, input logic vld,
		input logic lst);
		list_word_t w;
		w.status      = st;
		w.item_count  = COUNT_W'(list_model.size());
		w.entry_value = val;
		w.entry_valid = vld;
		w.last        = lst;
		pending_words.push_back(w);
	endfunction

	function automatic void apply_list_op(input logic [OP_W-1:0] op, input word_t value,
		input logic [POS_W-1:0] pos);
		status_t st;
		int      n;
		st = ST_OK;
		n  = list_model.size();
		case (op)
			OP_INSERT: begin
				if (pos < 1 || int'(pos) > n + 1)
					st = ST_BADPOS;
				else if (n >= CAPACITY)
					st = ST_FULL;
				else
					list_model.insert(int'(pos) - 1, value);
			end
			OP_DELETE: begin
				if (n == 0)
					st = ST_EMPTY;
				else if (pos < 1 || int'(pos) > n)
					st = ST_BADPOS;
				else
					list_model.delete(int'(pos) - 1);
			end
			OP_APPEND: begin
				if (n >= CAPACITY)
					st = ST_FULL;
				else
					list_model.push_back(value);
			end
			OP_REMOVE_TAIL: begin
				if (n == 0)
					st = ST_EMPTY;
				else
					void'(list_model.pop_back());
			end
			OP_READOUT: begin
				if (n == 0)
					push_expect(ST_EMPTY, '0, 1'b0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						push_expect(ST_OK, list_model[i], 1'b1, i == n - 1);
				return;
			end
			default: return;
		endcase
		push_expect(st, '0, 1'b0, 1'b1);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_cnt < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic issue_cmd(input int op, input word_t value, input int pos);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid    <= 1'b1;
		cmd_if.op       <= OP_W'(op);
		cmd_if.value    <= value;
		cmd_if.position <= POS_W'(pos);
		do @(posedge clk); while (!cmd_if.ready);
		apply_list_op(OP_W'(op), value, POS_W'(pos));
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_if.ready  <= 1'b0;
			rsp_hold_left = rsp_hold_left - 1;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got_word.status      = status_t'(rsp_if.status);
			got_word.item_count  = rsp_if.item_count;
			got_word.entry_value = rsp_if.entry_value;
			got_word.entry_valid = rsp_if.entry_valid;
			got_word.last        = rsp_if.last;
			if (pending_words.size() == 0) begin
				flag_mismatch("unexpected word", got_word.entry_value, '0);
			end else begin
				want_word = pending_words.pop_front();
				if (got_word.status !== want_word.status)
					flag_mismatch("status", 32'(got_word.status), 32'(want_word.status));
				if (got_word.item_count !== want_word.item_count)
					flag_mismatch("item_count", 32'(got_word.item_count),
						32'(want_word.item_count));
				if (got_word.entry_value !== want_word.entry_value)
					flag_mismatch("entry_value", got_word.entry_value, want_word.entry_value);
				if (got_word.entry_valid !== want_word.entry_valid)
					flag_mismatch("entry_valid", 32'(got_word.entry_valid),
						32'(want_word.entry_valid));
				if (got_word.last !== want_word.last)
					flag_mismatch("last", 32'(got_word.last), 32'(want_word.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_empty_list();
		issue_cmd(OP_READOUT, $urandom, $urandom_range(63));
		issue_cmd(OP_DELETE, $urandom, 1);
		issue_cmd(OP_REMOVE_TAIL, $urandom, $urandom_range(63));
		issue_cmd(OP_INSERT, $urandom, 0);
		issue_cmd(OP_INSERT, $urandom, 2);
	endtask

	task automatic test_edit_ops();
		issue_cmd(OP_INSERT, 32'h8000_0000, 1);
		issue_cmd(OP_APPEND, 32'h7FFF_FFFF, 0);
		issue_cmd(OP_INSERT, 32'hFFFF_FFFF, 3);
		issue_cmd(OP_INSERT, 32'h0000_0000, 2);
		issue_cmd(OP_INSERT, 32'h5555_AAAA, 1);
		issue_cmd(OP_READOUT, '0, 0);
		issue_cmd(OP_DELETE, '0, 0);
		issue_cmd(OP_DELETE, '0, 6);
		issue_cmd(OP_DELETE, '0, 63);
		issue_cmd(OP_INSERT, 32'hAAAA_5555, 63);
		issue_cmd(OP_DELETE, '0, 1);
		issue_cmd(OP_DELETE, '0, 4);
		issue_cmd(OP_REMOVE_TAIL, '0, 0);
		issue_cmd(OP_READOUT, '0, 0);
	endtask

	task automatic test_unused_ops();
		for (int c = OP_READOUT + 1; c < 2 ** OP_W; c++)
			issue_cmd(c, $urandom, $urandom_range(63));
		issue_cmd(OP_READOUT, '0, 0);
	endtask

	task automatic test_full_list();
		while (list_model.size() < CAPACITY)
			issue_cmd(OP_APPEND, $urandom, $urandom_range(63));
		issue_cmd(OP_APPEND, $urandom, 0);
		issue_cmd(OP_INSERT, $urandom, CAPACITY + 1);
		issue_cmd(OP_INSERT, $urandom, 1);
		issue_cmd(OP_INSERT, $urandom, CAPACITY + 2);
		issue_cmd(OP_READOUT, '0, 0);
		issue_cmd(OP_DELETE, '0, CAPACITY);
		issue_cmd(OP_DELETE, '0, 1);
		issue_cmd(OP_INSERT, $urandom, CAPACITY / 2);
		issue_cmd(OP_READOUT, '0, 0);
		while (list_model.size() > CAPACITY / 4)
			issue_cmd(OP_REMOVE_TAIL, $urandom, $urandom_range(63));
	endtask

	// mostly legal edits and readouts with random content, some raw noise
	task automatic test_random_ops(input int num_items, input int noise_pct);
		int n;
		int sel;
		int grow;
		for (int k = 0; k < num_items; k++) begin
			n = list_model.size();
			if ($urandom_range(99) < noise_pct) begin
				issue_cmd($urandom_range(2 ** OP_W - 1), $urandom, $urandom_range(63));
			end else begin
				sel  = $urandom_range(99);
				grow = (n < CAPACITY / 2) ? 60 : 35;
				if (sel < grow) begin
					if ($urandom_range(1))
						issue_cmd(OP_INSERT, $urandom, $urandom_range(n + 1, 1));
					else
						issue_cmd(OP_APPEND, $urandom, $urandom_range(63));
				end else if (sel < 90) begin
					if (n > 0 && $urandom_range(2) != 0)
						issue_cmd(OP_DELETE, $urandom, $urandom_range(n, 1));
					else
						issue_cmd(OP_REMOVE_TAIL, $urandom, $urandom_range(63));
				end else begin
					issue_cmd(OP_READOUT, $urandom, $urandom_range(63));
				end
			end
		end
	endtask

	// receiver stalls long while commands keep coming
	task automatic test_input_backpressure();
		rsp_hold_left = 200;
		for (int k = 0; k < 6; k++)
			issue_cmd(OP_APPEND, $urandom, $urandom_range(63));
		issue_cmd(OP_READOUT, '0, 0);
		for (int k = 0; k < 4; k++)
			issue_cmd(OP_DELETE, '0, 1);
		issue_cmd(OP_READOUT, '0, 0);
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.op       = '0;
		cmd_if.value    = '0;
		cmd_if.position = '0;
		rsp_if.ready    = 1'b0;
		mismatch_cnt    = 0;
		rsp_hold_left   = 0;
		idle_cycles     = 0;
		snd_idle_pct    = 6;
		rcv_idle_pct    = 48;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_list();
		test_edit_ops();
		test_unused_ops();
		test_full_list();
		test_random_ops(12, 15);
		snd_idle_pct = 48;
		rcv_idle_pct = 6;
		test_random_ops(12, 15);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_ops(12, 15);
		test_input_backpressure();

		cmd_if.valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ===== positional_list_store_core.f =====
+incdir+design
design/plsc_pkg.sv
design/plsc_in_if.sv
design/plsc_out_if.sv
design/plsc_ram.sv
design/plsc_ctrl.sv
design/positional_list_store_core.sv
design/plsc_checker.sv
tb/tb_positional_list_store_core.sv
